FILE: rtl/core/pkled_pkg.sv
package pkled_pkg;

    // field and register widths
    localparam int NOTE_W      = 7;
    localparam int LED_W       = 10;
    localparam int DENS_W      = 16;
    localparam int LEN_W       = 11;
    localparam int OFFS_W      = 20;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    // defaults for the top level parameters
    localparam int MAX_LEDS_DEF      = 1024;
    localparam int POS_FRAC_BITS_DEF = 8;

    // keyboard geometry, lengths in 1/140 mm
    localparam int NOTE_LOW    = 21;
    localparam int NOTE_HIGH   = 108;
    localparam int NOTE_COUNT  = 2 ** NOTE_W;
    localparam int OCTAVE140   = 23030;
    localparam int A0_EDGE140  = 17390;
    localparam int HALF_CE140  = 987;
    localparam int HALF_FB140  = 940;
    localparam int CENTER140 [12] = '{
        987, 2961, 4935, 6909, 8883,
        10810, 12690, 14570, 16450, 18330, 20210, 22090
    };

    // 1000 mm per meter times 16 density steps per led
    localparam int UNIT_SCALE = 16000;
    // twice the unit is DENS_DIV << (frac + 8)
    localparam int DENS_DIV   = 125;

    // position selectors for the key table
    localparam int POS_CENTER = 0;
    localparam int POS_LEFT   = 1;
    localparam int POS_RIGHT  = 2;

    // lanes of the conversion datapath
    localparam int LANE_FIRST = 0;
    localparam int LANE_LAST  = 1;
    localparam int LANE_NEAR  = 2;
    localparam int LANES      = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LED_DENSITY  = 2'd0,
        REG_STRIP_LENGTH = 2'd1,
        REG_KEY_OFFSET   = 2'd2
    } cfg_reg_t;

    // round half up from 1/140 mm to fixed point
    function automatic longint to_fixed(longint v140, int frac);
        return (v140 * (longint'(1) << frac) + 70) / 140;
    endfunction

    // key center or shrunk slot edge of a note, fixed point, zero off keyboard
    function automatic longint key_pos(longint note, int frac, int sel);
        longint rel;
        longint oct;
        longint n;
        longint c140;
        longint cfix;
        longint hfix;
        longint one;
        if (note < NOTE_LOW || note > NOTE_HIGH) begin
            return 0;
        end
        rel  = note - 12;
        oct  = rel / 12;
        n    = rel % 12;
        c140 = oct * OCTAVE140 + CENTER140[int'(n)] - A0_EDGE140;
        cfix = to_fixed(c140, frac);
        hfix = to_fixed((n < 5) ? HALF_CE140 : HALF_FB140, frac);
        one  = longint'(1) << frac;
        case (sel)
            POS_LEFT:  return cfix - hfix + one;
            POS_RIGHT: return cfix + hfix - one;
            default:   return cfix;
        endcase
    endfunction

endpackage

FILE: rtl/core/piano_key_to_led_range.sv
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+----------------------------------
// note      | in        | note_valid / note_stall    | midi_note
// result    | out       | result_valid / result_stall| range_valid, first_led, last_led
// cfg       | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// five register stages: key table and offset, density multiply, reciprocal
// multiply for the divide by 125, quotient correction, fallback and range check
// one word accepted per cycle while note_stall is low
// rst_n clears the stage valid bits and loads the register reset values
// a stall on the result side backs up stage by stage, bubbles are squeezed
// out, note_stall rises only when all five stages hold a word
module piano_key_to_led_range #(
    parameter int MAX_LEDS      = pkled_pkg::MAX_LEDS_DEF,
    parameter int POS_FRAC_BITS = pkled_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pkled_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pkled_pkg::CFG_DATA_W-1:0]  cfg_data,
    // note channel
    input  logic                              note_valid,
    output logic                              note_stall,
    input  logic [pkled_pkg::NOTE_W-1:0]      midi_note,
    // result channel
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              range_valid,
    output logic [pkled_pkg::LED_W-1:0]       first_led,
    output logic [pkled_pkg::LED_W-1:0]       last_led
);

    import pkled_pkg::*;

    localparam int F      = POS_FRAC_BITS;
    // key positions plus offset, signed
    localparam int PW     = ((F + 12 > 19) ? F + 12 : 19) + 2;
    // position times density
    localparam int PRW    = PW + DENS_W + 1;
    // doubled product plus unit term
    localparam int NW     = PRW + 2;
    // power of two part of the divisor
    localparam int SH     = F + 8;
    localparam int QW     = NW - SH;
    localparam int UW     = QW - 1;
    // reciprocal of 125, scaled by 2^UW
    localparam int MW     = UW - 6;
    localparam longint RECIP = (longint'(1) << UW) / DENS_DIV;
    localparam longint UNIT  = longint'(UNIT_SCALE) << F;
    // clamped strip length and the compare width
    localparam int CW     = $clog2(MAX_LEDS + 1);
    localparam int CLW    = (CW > LEN_W) ? CW : LEN_W;
    localparam int CMPW   = ((QW > CLW) ? QW : CLW) + 1;
    localparam int STAGES = 5;

    // configuration registers
    logic [DENS_W-1:0]        led_density_reg;
    logic [LEN_W-1:0]         strip_length_reg;
    logic signed [OFFS_W-1:0] key_offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_density_reg  <= DENS_W'(960);
            strip_length_reg <= '0;
            key_offset_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LED_DENSITY:  led_density_reg  <= cfg_data[DENS_W-1:0];
                REG_STRIP_LENGTH: strip_length_reg <= cfg_data[LEN_W-1:0];
                REG_KEY_OFFSET:   key_offset_reg   <= $signed(cfg_data[OFFS_W-1:0]);
                default:          ; // unknown register, write dropped
            endcase
        end
    end

    // key tables, built at elaboration, one entry per note code
    logic signed [PW-1:0] tab_center [NOTE_COUNT];
    logic signed [PW-1:0] tab_left   [NOTE_COUNT];
    logic signed [PW-1:0] tab_right  [NOTE_COUNT];

    for (genvar k = 0; k < NOTE_COUNT; k++)
    begin : g_key
        localparam longint KC = key_pos(k, F, POS_CENTER);
        localparam longint KL = key_pos(k, F, POS_LEFT);
        localparam longint KR = key_pos(k, F, POS_RIGHT);
        assign tab_center[k] = PW'(KC);
        assign tab_left[k]   = PW'(KL);
        assign tab_right[k]  = PW'(KR);
    end

    // stage valid bits and the ready chain
    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] rdy;

    always_comb
    begin
        rdy[STAGES-1] = !v_reg[STAGES-1] || !result_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign note_stall   = !rdy[0];
    assign result_valid = v_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= note_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 1: slot edges and center plus offset
    logic                 ok_s1_reg, ok_s1_next;
    logic signed [PW-1:0] pos_s1_reg  [LANES];
    logic signed [PW-1:0] pos_s1_next [LANES];

    always_comb
    begin
        ok_s1_next = (midi_note >= NOTE_W'(NOTE_LOW)) && (midi_note <= NOTE_W'(NOTE_HIGH));
        pos_s1_next[LANE_FIRST] = tab_left[midi_note]   + PW'(key_offset_reg);
        pos_s1_next[LANE_LAST]  = tab_right[midi_note]  + PW'(key_offset_reg);
        pos_s1_next[LANE_NEAR]  = tab_center[midi_note] + PW'(key_offset_reg);
    end

    // stage 2: scale by density
    logic                  ok_s2_reg;
    logic signed [PRW-1:0] prod_s2_reg  [LANES];
    logic signed [PRW-1:0] prod_s2_next [LANES];
    logic signed [DENS_W:0] dens_s;

    assign dens_s = $signed({1'b0, led_density_reg});

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            prod_s2_next[i] = PRW'(pos_s1_reg[i]) * PRW'(dens_s);
        end
    end

    // stage 3: led coordinate numerator, floor shift, reciprocal estimate
    logic                  ok_s3_reg;
    logic signed [NW-1:0]  num      [LANES];
    logic signed [QW-1:0]  qsh      [LANES];
    logic [UW+MW-1:0]      rp       [LANES];
    logic [MW-1:0]         recip_c;
    logic                  neg_s3_reg  [LANES];
    logic                  neg_s3_next [LANES];
    logic [UW-1:0]         u_s3_reg    [LANES];
    logic [UW-1:0]         u_s3_next   [LANES];
    logic [MW-1:0]         ap_s3_reg   [LANES];
    logic [MW-1:0]         ap_s3_next  [LANES];

    assign recip_c = MW'(RECIP);

    always_comb
    begin
        // first rounds up at led centers, last rounds down, nearest plain floor
        num[LANE_FIRST] = (NW'(prod_s2_reg[LANE_FIRST]) <<< 1) + NW'(UNIT - 1);
        num[LANE_LAST]  = (NW'(prod_s2_reg[LANE_LAST])  <<< 1) - NW'(UNIT);
        num[LANE_NEAR]  = (NW'(prod_s2_reg[LANE_NEAR])  <<< 1);
        for (int i = 0; i < LANES; i++)
        begin
            qsh[i]         = num[i][NW-1:SH];
            neg_s3_next[i] = qsh[i][QW-1];
            // negative values divide as the complement
            u_s3_next[i]   = qsh[i][QW-1] ? ~qsh[i][UW-1:0] : qsh[i][UW-1:0];
            rp[i]          = (UW+MW)'(u_s3_next[i]) * (UW+MW)'(recip_c);
            ap_s3_next[i]  = rp[i][UW+MW-1:UW];
        end
    end

    // stage 4: estimate is low by at most one, fix and restore sign
    logic                 ok_s4_reg;
    logic [UW-1:0]        rem   [LANES];
    logic [MW-1:0]        qu    [LANES];
    logic signed [QW-1:0] quo_s4_reg  [LANES];
    logic signed [QW-1:0] quo_s4_next [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            rem[i] = u_s3_reg[i] - UW'(UW'(ap_s3_reg[i]) * UW'(DENS_DIV));
            qu[i]  = ap_s3_reg[i] + MW'(rem[i] >= UW'(DENS_DIV));
            quo_s4_next[i] = neg_s3_reg[i] ? ~QW'(qu[i]) : QW'(qu[i]);
        end
    end

    // stage 5: empty span falls back to nearest led, then the strip check
    logic [CLW-1:0]         count_eff;
    logic signed [QW-1:0]   first_sel;
    logic signed [QW-1:0]   last_sel;
    logic signed [CMPW-1:0] cnt_ext;
    logic                   range_valid_reg, range_valid_next;
    logic [LED_W-1:0]       first_led_reg, first_led_next;
    logic [LED_W-1:0]       last_led_reg, last_led_next;

    always_comb
    begin
        if (CLW'(strip_length_reg) > CLW'(MAX_LEDS))
        begin
            count_eff = CLW'(MAX_LEDS);
        end
        else
        begin
            count_eff = CLW'(strip_length_reg);
        end
        cnt_ext = CMPW'($signed({1'b0, count_eff}));

        if (quo_s4_reg[LANE_LAST] < quo_s4_reg[LANE_FIRST])
        begin
            first_sel = quo_s4_reg[LANE_NEAR];
            last_sel  = quo_s4_reg[LANE_NEAR];
        end
        else
        begin
            first_sel = quo_s4_reg[LANE_FIRST];
            last_sel  = quo_s4_reg[LANE_LAST];
        end

        range_valid_next = ok_s4_reg && (led_density_reg != '0) && (count_eff != '0)
                           && !first_sel[QW-1] && (CMPW'(last_sel) < cnt_ext);
        first_led_next   = range_valid_next ? first_sel[LED_W-1:0] : '0;
        last_led_next    = range_valid_next ? last_sel[LED_W-1:0]  : '0;
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            ok_s1_reg  <= ok_s1_next;
            pos_s1_reg <= pos_s1_next;
        end
        if (rdy[1])
        begin
            ok_s2_reg   <= ok_s1_reg;
            prod_s2_reg <= prod_s2_next;
        end
        if (rdy[2])
        begin
            ok_s3_reg  <= ok_s2_reg;
            neg_s3_reg <= neg_s3_next;
            u_s3_reg   <= u_s3_next;
            ap_s3_reg  <= ap_s3_next;
        end
        if (rdy[3])
        begin
            ok_s4_reg  <= ok_s3_reg;
            quo_s4_reg <= quo_s4_next;
        end
        if (rdy[4])
        begin
            range_valid_reg <= range_valid_next;
            first_led_reg   <= first_led_next;
            last_led_reg    <= last_led_next;
        end
    end

    assign range_valid = range_valid_reg;
    assign first_led   = first_led_reg;
    assign last_led    = last_led_reg;

    // an invalid mapping carries zero indices
    a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !range_valid) |-> (first_led == '0 && last_led == '0))
        else $error("invalid range with nonzero indices");

    // span never runs backwards once the fallback is applied
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && range_valid && (MAX_LEDS <= 2 ** LED_W))
        |-> (first_led <= last_led))
        else $error("first led beyond last led");

    // a valid span lies on the strip
    a_on_strip: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && range_valid && (MAX_LEDS <= 2 ** LED_W))
        |-> (LEN_W'(last_led) < strip_length_reg && led_density_reg != '0))
        else $error("valid span off the strip");

    // back-pressure reaches the note side only with every stage full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        note_stall |-> (v_reg == '1))
        else $error("note stalled with a free stage");

endmodule
